@@ rtl/nir_pkg.sv @@
// ----------------------------------------------------------------------------
// nir_pkg: shared types and constants for the NEC IR frame receiver
// Register indexes, status and phase codes, configuration and result structs,
// and the acceptance window compare.
// ----------------------------------------------------------------------------
package nir_pkg;

  // Default frame geometry
  localparam int ADDRESS_BITS_DEF = 8;
  localparam int COMMAND_BITS_DEF = 8;

  // Field widths
  localparam int INTERVAL_W = 15;
  localparam int TOL_W      = 12;
  localparam int ID_W       = 8;
  localparam int MASK_W     = 3;
  localparam int OUT_W      = 8;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  // Widest address or command field the decoder supports
  localparam int FIELD_MAX_W = 16;

  // Register reset values
  localparam logic [INTERVAL_W-1:0] START_US_RST  = 15'd13500;
  localparam logic [INTERVAL_W-1:0] REPEAT_US_RST = 15'd11250;
  localparam logic [INTERVAL_W-1:0] ZERO_US_RST   = 15'd1125;
  localparam logic [INTERVAL_W-1:0] ONE_US_RST    = 15'd2250;
  localparam logic [TOL_W-1:0]      TOL_US_RST    = 12'd400;
  localparam logic [ID_W-1:0]       DEVICE_ID_RST = 8'd0;
  localparam logic [MASK_W-1:0]     CHECK_MASK_RST = 3'd3;

  // check_mask bit positions
  localparam int CHK_ADDR_BIT = 0;
  localparam int CHK_CMD_BIT  = 1;
  localparam int CHK_ID_BIT   = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_US  = 3'd0,
    REG_REPEAT_US = 3'd1,
    REG_ZERO_US   = 3'd2,
    REG_ONE_US    = 3'd3,
    REG_TOL_US    = 3'd4,
    REG_DEVICE_ID = 3'd5,
    REG_CHECK_MASK = 3'd6
  } cfg_reg_t;

  // Input beat command
  typedef enum logic {
    CMD_EDGE    = 1'b0,
    CMD_TIMEOUT = 1'b1
  } in_cmd_t;

  // Decoder phase
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_AWAIT = 2'd1,
    PH_RECV  = 2'd2
  } phase_t;

  // Result status
  typedef enum logic [STATUS_W-1:0] {
    ST_NONE   = 3'd0,
    ST_ACCEPT = 3'd1,
    ST_REJECT = 3'd2,
    ST_REPEAT = 3'd3,
    ST_SYMERR = 3'd4
  } status_t;

  typedef struct packed {
    logic [INTERVAL_W-1:0] start_us;
    logic [INTERVAL_W-1:0] repeat_us;
    logic [INTERVAL_W-1:0] zero_us;
    logic [INTERVAL_W-1:0] one_us;
    logic [TOL_W-1:0]      tol_us;
    logic [ID_W-1:0]       device_id;
    logic [MASK_W-1:0]     check_mask;
  } cfg_t;

  // Interval classification
  typedef struct packed {
    logic is_start;
    logic is_repeat;
    logic is_zero;
    logic is_one;
  } sym_t;

  typedef struct packed {
    status_t          status;
    logic [OUT_W-1:0] address;
    logic [OUT_W-1:0] command;
    logic [OUT_W-1:0] repeat_count;
  } result_t;

  // Open window: nominal - tol < t < nominal + tol, computed without underflow
  function automatic logic in_window(input logic [INTERVAL_W-1:0] t,
                                     input logic [INTERVAL_W-1:0] nominal,
                                     input logic [TOL_W-1:0]      tol);
    logic [INTERVAL_W:0] t_hi;
    logic [INTERVAL_W:0] n_hi;
    t_hi = {1'b0, t} + {{(INTERVAL_W-TOL_W+1){1'b0}}, tol};
    n_hi = {1'b0, nominal} + {{(INTERVAL_W-TOL_W+1){1'b0}}, tol};
    return (t_hi > {1'b0, nominal}) && ({1'b0, t} < n_hi);
  endfunction

endpackage

@@ rtl/nir_cfg.sv @@
// ----------------------------------------------------------------------------
// nir_cfg: configuration register file
// Seven write-only registers loaded from the configuration channel.
// ----------------------------------------------------------------------------
module nir_cfg
  import nir_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Writes are always accepted
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Register decode; unused indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_US:   cfg_nxt.start_us   = cfg_wdata;
        REG_REPEAT_US:  cfg_nxt.repeat_us  = cfg_wdata;
        REG_ZERO_US:    cfg_nxt.zero_us    = cfg_wdata;
        REG_ONE_US:     cfg_nxt.one_us     = cfg_wdata;
        REG_TOL_US:     cfg_nxt.tol_us     = cfg_wdata[TOL_W-1:0];
        REG_DEVICE_ID:  cfg_nxt.device_id  = cfg_wdata[ID_W-1:0];
        REG_CHECK_MASK: cfg_nxt.check_mask = cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_us   <= START_US_RST;
      cfg_r.repeat_us  <= REPEAT_US_RST;
      cfg_r.zero_us    <= ZERO_US_RST;
      cfg_r.one_us     <= ONE_US_RST;
      cfg_r.tol_us     <= TOL_US_RST;
      cfg_r.device_id  <= DEVICE_ID_RST;
      cfg_r.check_mask <= CHECK_MASK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ rtl/nir_window.sv @@
// ----------------------------------------------------------------------------
// nir_window: interval classifier
// Compares one interval against the four acceptance windows.
// ----------------------------------------------------------------------------
module nir_window
  import nir_pkg::*;
(
  input  cfg_t                  cfg,
  input  logic [INTERVAL_W-1:0] interval_us,
  output sym_t                  sym
);

  // Four independent window compares; priority is applied in the decoder
  always_comb begin
    sym.is_start  = in_window(interval_us, cfg.start_us,  cfg.tol_us);
    sym.is_repeat = in_window(interval_us, cfg.repeat_us, cfg.tol_us);
    sym.is_zero   = in_window(interval_us, cfg.zero_us,   cfg.tol_us);
    sym.is_one    = in_window(interval_us, cfg.one_us,    cfg.tol_us);
  end

endmodule

@@ rtl/nir_decoder.sv @@
// ----------------------------------------------------------------------------
// nir_decoder: frame state machine
// Tracks phase, assembles frame bits LSB first, checks completed frames and
// counts repeat codes. Produces one result per step.
// ----------------------------------------------------------------------------
module nir_decoder
  import nir_pkg::*;
#(
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
  parameter int COMMAND_BITS = COMMAND_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  in_cmd_t cmd,
  input  sym_t    sym,
  input  cfg_t    cfg,
  output result_t res
);

  localparam int TOTAL = 2 * (ADDRESS_BITS + COMMAND_BITS);
  localparam int POS_W = $clog2(TOTAL);
  localparam int AI_LO = ADDRESS_BITS;
  localparam int C_LO  = 2 * ADDRESS_BITS;
  localparam int CI_LO = 2 * ADDRESS_BITS + COMMAND_BITS;

  phase_t             phase_r, phase_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [TOTAL-1:0]   frame_r, frame_nxt;
  logic               armed_r, armed_nxt;
  logic [OUT_W-1:0]   tally_r, tally_nxt;

  logic [ADDRESS_BITS-1:0] addr_f, addr_inv_f;
  logic [COMMAND_BITS-1:0] cmd_f, cmd_inv_f;
  logic [FIELD_MAX_W-1:0]  addr_ext, cmd_ext;
  logic                    last_bit;
  logic                    frame_ok;

  // Fields of the frame as it stands after this step
  assign addr_f     = frame_nxt[AI_LO-1:0];
  assign addr_inv_f = frame_nxt[C_LO-1:AI_LO];
  assign cmd_f      = frame_nxt[CI_LO-1:C_LO];
  assign cmd_inv_f  = frame_nxt[TOTAL-1:CI_LO];
  assign addr_ext   = FIELD_MAX_W'(addr_f);
  assign cmd_ext    = FIELD_MAX_W'(cmd_f);
  assign last_bit   = (pos_r == POS_W'(TOTAL - 1));

  // Enabled checks on a completed frame
  always_comb begin
    frame_ok = 1'b1;
    if (cfg.check_mask[CHK_ADDR_BIT] && ((addr_f ^ addr_inv_f) != '1)) frame_ok = 1'b0;
    if (cfg.check_mask[CHK_CMD_BIT] && ((cmd_f ^ cmd_inv_f) != '1)) frame_ok = 1'b0;
    if (cfg.check_mask[CHK_ID_BIT] && (addr_ext != FIELD_MAX_W'(cfg.device_id)))
      frame_ok = 1'b0;
  end

  // Next state and result
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    frame_nxt = frame_r;
    armed_nxt = armed_r;
    tally_nxt = tally_r;
    res.status  = ST_NONE;
    res.address = '0;
    res.command = '0;
    if (cmd == CMD_TIMEOUT) begin
      phase_nxt = PH_IDLE;
    end else begin
      case (phase_r)
        PH_AWAIT: begin
          phase_nxt = PH_IDLE;
          if (sym.is_start) begin
            phase_nxt = PH_RECV;
            pos_nxt   = '0;
            frame_nxt = '0;
            armed_nxt = 1'b0;
            tally_nxt = '0;
          end else if (armed_r && sym.is_repeat) begin
            tally_nxt  = tally_r + 1'b1;
            res.status = ST_REPEAT;
          end
        end
        PH_RECV: begin
          if (!sym.is_zero && !sym.is_one) begin
            // bad bit interval
            phase_nxt  = PH_IDLE;
            pos_nxt    = '0;
            res.status = ST_SYMERR;
          end else begin
            frame_nxt[pos_r] = !sym.is_zero;
            pos_nxt          = pos_r + 1'b1;
            if (last_bit) begin
              phase_nxt   = PH_IDLE;
              pos_nxt     = '0;
              armed_nxt   = 1'b1;
              res.address = addr_ext[OUT_W-1:0];
              if (frame_ok) begin
                res.status  = ST_ACCEPT;
                res.command = cmd_ext[OUT_W-1:0];
              end else begin
                res.status = ST_REJECT;
              end
            end
          end
        end
        default: begin
          phase_nxt = PH_AWAIT;
        end
      endcase
    end
    res.repeat_count = tally_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      frame_r <= '0;
      armed_r <= 1'b0;
      tally_r <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      frame_r <= frame_nxt;
      armed_r <= armed_nxt;
      tally_r <= tally_nxt;
    end
  end

endmodule

@@ rtl/nec_ir_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// nec_ir_frame_receiver: NEC-style infrared frame decoder
// Input register, interval classifier, frame state machine, result register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one beat per falling edge (in_cmd = 0, in_interval_us
//   holds microseconds since the previous edge) or per timer overflow
//   (in_cmd = 1, forces the decoder idle).
//   Result channel (out_*): exactly one beat per input beat, in order, with
//   status, address, command and the repeat count after that step.
//   Config channel (cfg_*): cfg_index selects one of seven registers; always
//   ready. Write only while no input beat is in flight.
//   Throughput: one beat per cycle while out_ready is high; the input
//   register and the result register form a two-stage pipe, and each step
//   is a handful of 16-bit compares plus one bit insert.
//   Stall: when out_ready is low the result register holds; the input
//   register still takes one more beat if it is empty, then in_ready drops.
//   Reset: rst_n (synchronous) loads the register defaults, puts the decoder
//   idle with repeat count zero and empties both pipe registers.
// ----------------------------------------------------------------------------
module nec_ir_frame_receiver
  import nir_pkg::*;
#(
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
  parameter int COMMAND_BITS = COMMAND_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_cmd,
  input  logic [INTERVAL_W-1:0] in_interval_us,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic [OUT_W-1:0]      out_address,
  output logic [OUT_W-1:0]      out_command,
  output logic [OUT_W-1:0]      out_repeat_count,
  // configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t                  cfg;
  sym_t                  sym;
  result_t               res;
  logic                  s1_valid_r;
  in_cmd_t               s1_cmd_r;
  logic [INTERVAL_W-1:0] s1_interval_r;
  logic                  out_valid_r;
  result_t               out_r;
  logic                  advance;
  logic                  step_en;

  // Pipe control: result register frees when empty or taken
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign step_en  = s1_valid_r && advance;

  nir_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  nir_window u_window (
    .cfg         (cfg),
    .interval_us (s1_interval_r),
    .sym         (sym)
  );

  nir_decoder #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .COMMAND_BITS (COMMAND_BITS)
  ) u_decoder (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .cmd     (s1_cmd_r),
    .sym     (sym),
    .cfg     (cfg),
    .res     (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r      <= in_cmd_t'(in_cmd);
      s1_interval_r <= in_interval_us;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_address      = out_r.address;
  assign out_command      = out_r.command;
  assign out_repeat_count = out_r.repeat_count;

endmodule

@@ rtl/nir_checker.sv @@
// ----------------------------------------------------------------------------
// nir_checker: port-level checks for the NEC IR frame receiver
// Watches the result channel for stall behavior and field consistency.
// ----------------------------------------------------------------------------
module nir_checker
  import nir_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [OUT_W-1:0]    out_address,
  input logic [OUT_W-1:0]    out_command,
  input logic [OUT_W-1:0]    out_repeat_count
);

  // Stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_address) && $stable(out_command) && $stable(out_repeat_count))
    else $error("result beat changed while stalled");

  // Status code stays in range
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_SYMERR)
    else $error("illegal status code");

  // Command only carried by an accepted frame
  a_cmd_only_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_ACCEPT |-> out_command == '0)
    else $error("command on non-accepted beat");

  // Address only carried by a completed frame
  a_addr_only_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_ACCEPT && out_status != ST_REJECT |->
    out_address == '0)
    else $error("address on non-frame beat");

endmodule

bind nec_ir_frame_receiver nir_checker u_nir_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_address      (out_address),
  .out_command      (out_command),
  .out_repeat_count (out_repeat_count)
);
